>>> rtl/pffia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pffia_pkg: shared types for the preferred-start first-fit allocator
// Transaction payloads and the control bundle that drives the cell ring.
// ----------------------------------------------------------------------------
package pffia_pkg;

  typedef struct packed {
    logic [31:0] preferred_start;
    logic [23:0] duration;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [31:0] grant_start;
    logic [31:0] grant_end;
  } rsp_t;

  typedef struct packed {
    logic shift;  // every cell takes its neighbor's entry
    logic init;   // reload the single initial free interval
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/preferred_first_fit_interval_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// preferred_first_fit_interval_allocator: free-interval allocator
// Free intervals sit sorted in a ring of MAX_INTERVALS-1 cells that rotates
// past one head unit; one full rotation is one pass over the free list.
// ----------------------------------------------------------------------------
// Sequence: the request is accepted, then a preferred-start pass over the
//   ring, plus a second pass when the grant falls back to first fit; the
//   result then sits in the output register. Zero length skips the passes.
// Throughput: one transaction at a time, set by the ring rotation length.
// Reset (rst, synchronous): space end 2^32-1 (masked to ADDR_BITS), free list
//   is the single interval [1, space end], entry counter 1. A space end write
//   reloads the same way.
module preferred_first_fit_interval_allocator #(
  parameter int MAX_INTERVALS = 1024,
  parameter int ADDR_BITS     = 32
) (
  input  wire                clk,
  input  wire                rst,
  // request channel
  input  wire                req_valid,
  output logic               req_stall,
  input  pffia_pkg::req_t    req,
  // response channel
  output logic               rsp_valid,
  input  wire                rsp_stall,
  output pffia_pkg::rsp_t    rsp,
  // configuration port
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pffia_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int N  = MAX_INTERVALS - 1;          // ring slots; slot 0 sits at the head unit
  localparam int EW = ((AW > 24) ? AW : 24) + 1;  // room for end and length
  localparam int PW = $clog2(N);
  localparam int UW = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN1 = 2'd1;  // preferred-start pass
  localparam logic [1:0] S_SCAN2 = 2'd2;  // first-fit apply pass
  localparam logic [1:0] S_RSP   = 2'd3;

  localparam logic REG_SPACE_END = 1'b0;

  logic [1:0]    state;
  logic [AW-1:0] space_end;
  logic [UW-1:0] entries_used;
  logic [AW-1:0] s;
  logic [EW-1:0] d;
  logic [EW-1:0] e;
  logic [PW-1:0] pos;
  logic [PW-1:0] ff_pos;
  logic          ff_found;
  logic          done;
  logic          carry_v;
  logic [AW-1:0] carry_lo, carry_hi;

  // ring
  logic          cv  [N];
  logic [AW-1:0] clo [N];
  logic [AW-1:0] chi [N];
  cell_ctl_t     ctl;
  logic [AW-1:0] init_hi;
  logic          tail_v;
  logic [AW-1:0] tail_lo, tail_hi;

  logic cfg_wr;
  assign pready = 1'b1;
  assign prdata = 32'(space_end);
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SPACE_END);

  assign init_hi   = rst ? AW'(32'hFFFF_FFFF) : AW'(pwdata);
  assign ctl.init  = cfg_wr;
  assign ctl.shift = (state == S_SCAN1) || (state == S_SCAN2);

  for (genvar i = 0; i < N; i++) begin : g_ring
    if (i == N - 1) begin : g_tail
      pffia_cell #(.AW(AW), .FIRST(i == 0)) u_cell (
        .clk, .rst, .ctl, .init_hi,
        .nxt_valid(tail_v), .nxt_lo(tail_lo), .nxt_hi(tail_hi),
        .valid(cv[i]), .lo(clo[i]), .hi(chi[i])
      );
    end else begin : g_mid
      pffia_cell #(.AW(AW), .FIRST(i == 0)) u_cell (
        .clk, .rst, .ctl, .init_hi,
        .nxt_valid(cv[i+1]), .nxt_lo(clo[i+1]), .nxt_hi(chi[i+1]),
        .valid(cv[i]), .lo(clo[i]), .hi(chi[i])
      );
    end
  end

  // head unit: looks at slot 0 as it goes by
  logic [EW-1:0] hlo_e, hhi_e, s_e, len;
  logic          eover, full, act_con, act_ff, ffok, split_ok;
  logic          p0_v, p1_v;
  logic [AW-1:0] p0_lo, p0_hi, p1_lo, p1_hi;
  logic          res_set, res_ok;
  logic [AW-1:0] res_lo, res_hi;

  always_comb begin
    hlo_e   = EW'(clo[0]);
    hhi_e   = EW'(chi[0]);
    s_e     = EW'(s);
    len     = hhi_e - hlo_e + EW'(1);
    eover   = (e >> AW) != '0;
    full    = entries_used >= UW'(MAX_INTERVALS - 1);
    act_con = (state == S_SCAN1) && !done && cv[0] && (hlo_e <= s_e) && !eover
              && (hhi_e >= e);
    act_ff  = (state == S_SCAN2) && !done && (pos == ff_pos);
    ffok    = (state == S_SCAN1) && !ff_found && cv[0] && (len >= d);
    split_ok = 1'b0;
    p0_v  = cv[0];
    p0_lo = clo[0];
    p0_hi = chi[0];
    p1_v  = 1'b0;
    p1_lo = AW'(AW'(e) + AW'(1));
    p1_hi = chi[0];
    res_set = 1'b0;
    res_ok  = 1'b0;
    res_lo  = s;
    res_hi  = AW'(e);
    if (act_con) begin
      res_set = 1'b1;
      res_ok  = 1'b1;
      if ((hlo_e < s_e) && (hhi_e > e)) begin
        if (full) begin
          res_ok = 1'b0;  // split needs a fresh entry and none is left
        end else begin
          split_ok = 1'b1;
          p0_hi    = s - AW'(1);
          p1_v     = 1'b1;
        end
      end else if ((hlo_e == s_e) && (hhi_e > e)) begin
        p0_lo = AW'(AW'(e) + AW'(1));
      end else if (hlo_e < s_e) begin
        p0_hi = s - AW'(1);
      end else begin
        p0_v = 1'b0;
      end
    end else if (act_ff) begin
      res_set = 1'b1;
      res_ok  = 1'b1;
      res_lo  = clo[0];
      res_hi  = AW'(hlo_e + d - EW'(1));
      if (len > d) begin
        p0_lo = AW'(hlo_e + d);
      end else begin
        p0_v = 1'b0;
      end
    end
    // the carry keeps the list compact and in order after a split
    if (carry_v) begin
      tail_v  = 1'b1;
      tail_lo = carry_lo;
      tail_hi = carry_hi;
    end else begin
      tail_v  = p0_v;
      tail_lo = p0_lo;
      tail_hi = p0_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      space_end    <= AW'(32'hFFFF_FFFF);
      entries_used <= UW'(1);
      carry_v      <= 1'b0;
      done         <= 1'b0;
      ff_found     <= 1'b0;
      pos          <= '0;
    end else begin
      if (cfg_wr) begin
        space_end    <= AW'(pwdata);
        entries_used <= UW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            s        <= AW'(req.preferred_start);
            d        <= EW'(req.duration);
            e        <= EW'(AW'(req.preferred_start)) + EW'(req.duration) - EW'(1);
            pos      <= '0;
            done     <= 1'b0;
            ff_found <= 1'b0;
            carry_v  <= 1'b0;
            rsp      <= '0;
            state    <= (req.duration == '0) ? S_RSP : S_SCAN1;
          end
        end
        S_SCAN1, S_SCAN2: begin
          if (carry_v) begin
            carry_v  <= p0_v;
            carry_lo <= p0_lo;
            carry_hi <= p0_hi;
          end else begin
            carry_v  <= p1_v;
            carry_lo <= p1_lo;
            carry_hi <= p1_hi;
          end
          if (split_ok) begin
            entries_used <= entries_used + UW'(1);
          end
          if (ffok) begin
            ff_found <= 1'b1;
            ff_pos   <= pos;
          end
          if (res_set) begin
            done             <= 1'b1;
            rsp.granted      <= res_ok;
            rsp.grant_start  <= res_ok ? 32'(res_lo) : 32'd0;
            rsp.grant_end    <= res_ok ? 32'(res_hi) : 32'd0;
          end
          if (pos == PW'(N - 1)) begin
            pos <= '0;
            if ((state == S_SCAN1) && !done && !res_set && (ff_found || ffok)) begin
              state <= S_SCAN2;
            end else begin
              state <= S_RSP;
            end
          end else begin
            pos <= pos + PW'(1);
          end
        end
        S_RSP: begin
          if (!rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_RSP);

endmodule
`default_nettype wire

>>> rtl/pffia_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pffia_cell: one slot of the free-interval ring
// Holds one free interval and passes it toward the head on each shift.
// ----------------------------------------------------------------------------
module pffia_cell #(
  parameter int AW    = 32,
  parameter bit FIRST = 1'b0
) (
  input  wire                   clk,
  input  wire                   rst,
  input  pffia_pkg::cell_ctl_t  ctl,
  input  wire  [AW-1:0]         init_hi,
  input  wire                   nxt_valid,
  input  wire  [AW-1:0]         nxt_lo,
  input  wire  [AW-1:0]         nxt_hi,
  output logic                  valid,
  output logic [AW-1:0]         lo,
  output logic [AW-1:0]         hi
);
  import pffia_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      // only the first slot starts with an interval, [1, space end], if that end is nonzero
      valid <= FIRST && (init_hi != '0);
      lo    <= AW'(1);
      hi    <= init_hi;
    end else if (ctl.shift) begin
      valid <= nxt_valid;
      lo    <= nxt_lo;
      hi    <= nxt_hi;
    end
  end

endmodule
`default_nettype wire

>>> tb/preferred_first_fit_interval_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// preferred_first_fit_interval_allocator_tb: self-checking allocator bench
// Drives allocation requests with random gaps and stalls, predicts each grant
// from a free-interval table kept in the bench, and compares every response.
// ----------------------------------------------------------------------------
module preferred_first_fit_interval_allocator_tb;
  import pffia_pkg::*;

  localparam int SLOTS = 1024;
  localparam int ITEMS = 580;
  localparam logic [2:0] SPACE_END_ADDR = 3'd0;

  // --------------------------------------------------------------------------
  // Grant scoreboard: a free-list predictor plus a queue of pending grants
  // --------------------------------------------------------------------------
  class grant_scoreboard;
    bit [31:0] space_end;
    bit [32:0] lo_tab [SLOTS];
    bit [32:0] hi_tab [SLOTS];
    int        prv [SLOTS];
    int        nxt [SLOTS];
    int        head;
    int        used;
    rsp_t      pending [$];
    int        errors;

    function void reload(bit [31:0] se);
      space_end = se;
      foreach (lo_tab[i]) begin
        lo_tab[i] = 0; hi_tab[i] = 0; prv[i] = 0; nxt[i] = 0;
      end
      used = 1;
      if (se == 0) begin
        head = 0;
      end else begin
        lo_tab[1] = 1;
        hi_tab[1] = se;
        head = 1;
      end
    endfunction

    function void drop(int j);
      int p;
      int q;
      p = prv[j];
      q = nxt[j];
      if (p == 0) head = q;
      else nxt[p] = q;
      if (q != 0) prv[q] = p;
    endfunction

    function rsp_t allocate(req_t r);
      rsp_t      g;
      bit [32:0] s, d, e, lo, hi, len;
      int        j, k, steps;
      g = '0;
      s = r.preferred_start;
      d = r.duration;
      if (d == 0) return g;
      e = s + d - 1;
      // preferred-start pass
      j = head;
      steps = 0;
      while (j != 0 && steps < SLOTS) begin
        lo = lo_tab[j];
        hi = hi_tab[j];
        if (lo > s) break;
        if (e <= 33'hFFFF_FFFF && hi >= e) begin
          if (lo < s && hi > e) begin
            if (used + 1 >= SLOTS) return g;
            k = used + 1;
            used = k;
            lo_tab[k] = e + 1;
            hi_tab[k] = hi;
            prv[k] = j;
            nxt[k] = nxt[j];
            if (nxt[j] != 0) prv[nxt[j]] = k;
            hi_tab[j] = s - 1;
            nxt[j] = k;
          end else if (lo == s && hi > e) begin
            lo_tab[j] = e + 1;
          end else if (lo < s) begin
            hi_tab[j] = s - 1;
          end else begin
            drop(j);
          end
          g.granted = 1'b1;
          g.grant_start = s[31:0];
          g.grant_end = e[31:0];
          return g;
        end
        j = nxt[j];
        steps++;
      end
      // first-fit pass
      j = head;
      steps = 0;
      while (j != 0 && steps < SLOTS) begin
        lo = lo_tab[j];
        hi = hi_tab[j];
        len = hi - lo + 1;
        if (len >= d) begin
          if (len > d) lo_tab[j] = lo + d;
          else drop(j);
          g.granted = 1'b1;
          g.grant_start = lo[31:0];
          g.grant_end = 32'(lo + d - 1);
          return g;
        end
        j = nxt[j];
        steps++;
      end
      return g;
    endfunction

    function void note_request(req_t r);
      pending.push_back(allocate(r));
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_grant(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected response %p", got));
        return;
      end
      want = pending.pop_front();
      if (got.granted !== want.granted)
        report($sformatf("granted got %0b want %0b", got.granted, want.granted));
      if (got.grant_start !== want.grant_start)
        report($sformatf("grant_start got %0h want %0h", got.grant_start, want.grant_start));
      if (got.grant_end !== want.grant_end)
        report($sformatf("grant_end got %0h want %0h", got.grant_end, want.grant_end));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  grant_scoreboard sb;
  bit              hold_rsp;   // long receiver hold-off request

  preferred_first_fit_interval_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Register write: setup phase, then access phase.
  task automatic write_space_end(bit [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= SPACE_END_ADDR; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.reload(value);
  endtask

  // One request transaction; valid stays up across back-to-back items.
  task automatic send_request(bit [31:0] start, bit [23:0] len);
    req_t r;
    r.preferred_start = start;
    r.duration = len;
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Wait until every grant is back, then give the block time to settle.
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);
  endtask

  // Random request shaped against the current space size.
  task automatic random_request(bit [31:0] se);
    bit [31:0] s;
    bit [23:0] d;
    int        pick;
    pick = $urandom_range(0, 9);
    if (pick < 6 && se != 0) s = $urandom_range(1, se);
    else s = $urandom;
    pick = $urandom_range(0, 9);
    if (pick < 6) d = 24'($urandom_range(1, 64));
    else if (pick < 8) d = 24'($urandom_range(1, 24'hFFFFFF));
    else if (pick < 9) d = '0;
    else d = 24'hFFFFFF;
    send_request(s, d);
    idle_sender(gap_len());
  endtask

  // Response side: random stalls plus the long hold-off when asked.
  initial begin
    rsp_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) sb.check_grant(rsp);
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  // Long hold-off counted here while the sender keeps offering.
  task automatic long_hold();
    int n;
    hold_rsp = 1'b1;
    for (n = 0; n < 6 * SLOTS; n++) @(posedge clk);
    hold_rsp = 1'b0;
  endtask

  initial begin
    bit [31:0] se;
    int        i;
    sb = new();
    rst = 1'b1;
    hold_rsp = 1'b0;
    req_valid = 1'b0; req = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sb.reload(32'hFFFF_FFFF);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes at reset configuration
    send_request(32'h1, 24'h1);
    send_request(32'hFFFF_FFFF, 24'hFFFFFF);  // range past the space
    send_request(32'hFFFF_FFFF, 24'h1);       // unlinks nothing, trims back
    send_request(32'h10, 24'h0);              // zero length
    send_request(32'h100, 24'h10);            // already taken, first fit
    send_request(32'h100, 24'h10);            // taken, first fit
    send_request(32'h2, 24'h1);               // trims front
    send_request(32'h80000000, 24'hFFFFFF);
    drain();

    // small space: whole-interval unlinks and refusals
    write_space_end(32'd20);
    se = 20;
    send_request(32'd5, 24'd3);
    send_request(32'd1, 24'd4);               // unlink first entry
    send_request(32'd8, 24'd13);              // unlink last
    send_request(32'd1, 24'd1);               // nothing fits
    drain();

    // empty table
    write_space_end(32'd0);
    send_request(32'd1, 24'd1);
    send_request(32'hFFFF_FFFF, 24'hFFFFFF);
    drain();

    // full space again; repeated splits under a long response hold-off
    write_space_end(32'hFFFF_FFFF);
    se = 32'hFFFF_FFFF;
    fork
      long_hold();
    join_none
    for (i = 0; i < 200; i++) begin
      send_request(32'd100 + i * 1000, 24'd10);
      idle_sender(gap_len());
    end
    drain();

    // random phases over several space sizes
    for (i = 0; i < 380; i++) begin
      if (i == 120) begin
        drain();
        se = $urandom_range(50, 5000);
        write_space_end(se);
      end else if (i == 250) begin
        drain();
        se = 32'd1;
        write_space_end(se);
      end else if (i == 270) begin
        drain();
        se = 32'hFFFF_FFFF;
        write_space_end(se);
      end
      random_request(se);
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #120ms;
    $display("Verification failed");
    $finish;
  end

endmodule
